[design/ffpa_pkg.sv]
// Shared types and constants of the first-fit page allocator.
// Used by ffpa_cell, first_fit_page_allocator and ffpa_checker; depends on nothing.
package ffpa_pkg;

	localparam int MAX_CHUNKS_DEF = 64;
	localparam int PAGE_W         = 44;
	localparam int COUNT_W        = 24;
	localparam int TOTAL_OUT_W    = 31;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_ZERO  = 2'd3;

	typedef struct packed {
		logic               kind;
		logic [PAGE_W-1:0]  page;
		logic [COUNT_W-1:0] count;
	} ffpa_req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [PAGE_W-1:0]      alloc_page;
		logic [TOTAL_OUT_W-1:0] free_total;
	} ffpa_rsp_t;

	typedef struct packed {
		logic               push;
		logic               alloc;
		logic [COUNT_W-1:0] count;
	} ffpa_ctl_t;

	typedef struct packed {
		logic              found;
		logic              remove;
		logic [PAGE_W-1:0] page;
	} ffpa_link_t;

endpackage

[design/ffpa_cell.sv]
// One list position of the allocator: holds a chunk start and size.
// Depends on ffpa_pkg; chained head to tail by first_fit_page_allocator.
module ffpa_cell (
	input  logic                          clk,
	input  logic                          capture,
	input  logic [ffpa_pkg::COUNT_W-1:0]  in_count,
	input  logic                          occupied,
	input  ffpa_pkg::ffpa_ctl_t           ctl,
	input  logic [ffpa_pkg::PAGE_W-1:0]   left_start,
	input  logic [ffpa_pkg::COUNT_W-1:0]  left_size,
	input  logic [ffpa_pkg::PAGE_W-1:0]   right_start,
	input  logic [ffpa_pkg::COUNT_W-1:0]  right_size,
	input  ffpa_pkg::ffpa_link_t          link_in,
	output ffpa_pkg::ffpa_link_t          link_out,
	output logic [ffpa_pkg::PAGE_W-1:0]   start_q,
	output logic [ffpa_pkg::COUNT_W-1:0]  size_q
);

	logic fit_s1;
	logic exact_s1;
	logic fit_eff;
	logic take_right;

	always_ff @(posedge clk) begin
		if (capture) begin
			fit_s1   <= occupied && (size_q >= in_count);
			exact_s1 <= (size_q == in_count);
		end
	end

	assign fit_eff    = fit_s1 && !link_in.found;
	assign take_right = link_in.remove || (fit_eff && exact_s1);

	always_comb begin
		link_out.found  = link_in.found || fit_s1;
		link_out.remove = take_right;
		link_out.page   = link_in.found ? link_in.page :
			(fit_s1 ? start_q : '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			start_q <= left_start;
			size_q  <= left_size;
		end else if (ctl.alloc) begin
			if (take_right) begin
				start_q <= right_start;
				size_q  <= right_size;
			end else if (fit_eff) begin
				start_q <= start_q + ffpa_pkg::PAGE_W'(ctl.count);
				size_q  <= size_q - ctl.count;
			end
		end
	end

endmodule

[design/first_fit_page_allocator.sv]
// Top level of the first-fit page allocator: request register, fill count,
// free total and a chain of ffpa_cell instances. Depends on ffpa_pkg, ffpa_cell.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------
//  request   | start & !busy accepts   | request (ffpa_req_t)
//  result    | done, one cycle         | result  (ffpa_rsp_t)
//
// In each transaction the accept edge captures the size compare in every cell
// and raises busy; while busy the first-fit chain ripples through all cells,
// and the edge that ends busy updates them. done rises with busy already low,
// so the next request is taken in the done cycle. The result cannot be stalled.
// Reset empties the list and clears the free total at once; chunk storage
// holds no reset value and needs no clearing pass.
module first_fit_page_allocator #(
	parameter int MAX_CHUNKS = ffpa_pkg::MAX_CHUNKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ffpa_pkg::ffpa_req_t request,
	output logic                done,
	output ffpa_pkg::ffpa_rsp_t result
);

	localparam int FILL_W  = $clog2(MAX_CHUNKS + 1);
	localparam int TOTAL_W = FILL_W + ffpa_pkg::COUNT_W;
	localparam int OUT_W   = ffpa_pkg::TOTAL_OUT_W;

	logic                 accept;
	logic                 busy_q;
	logic                 done_q;
	ffpa_pkg::ffpa_req_t  req_q;
	ffpa_pkg::ffpa_rsp_t  result_q;
	logic [FILL_W-1:0]    fill_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [TOTAL_W-1:0]   total_next;
	logic [FILL_W-1:0]    fill_next;
	logic [OUT_W-1:0]     total_out;
	ffpa_pkg::ffpa_ctl_t  ctl;
	ffpa_pkg::ffpa_rsp_t  rsp;
	ffpa_pkg::ffpa_link_t link_w [MAX_CHUNKS+1];
	logic [ffpa_pkg::PAGE_W-1:0]  start_w [MAX_CHUNKS];
	logic [ffpa_pkg::COUNT_W-1:0] size_w  [MAX_CHUNKS];
	logic [MAX_CHUNKS-1:0] occ;
	logic zero_cnt;
	logic full;
	logic found;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	assign link_w[0] = '{found: 1'b0, remove: 1'b0, page: '0};

	genvar g;
	generate
		for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
			logic [ffpa_pkg::PAGE_W-1:0]  l_start;
			logic [ffpa_pkg::COUNT_W-1:0] l_size;
			logic [ffpa_pkg::PAGE_W-1:0]  r_start;
			logic [ffpa_pkg::COUNT_W-1:0] r_size;

			assign occ[g] = (fill_q > FILL_W'(g));

			if (g == 0) begin : g_head
				assign l_start = req_q.page;
				assign l_size  = req_q.count;
			end else begin : g_mid
				assign l_start = start_w[g-1];
				assign l_size  = size_w[g-1];
			end

			if (g == MAX_CHUNKS - 1) begin : g_tail
				assign r_start = start_w[g];
				assign r_size  = size_w[g];
			end else begin : g_body
				assign r_start = start_w[g+1];
				assign r_size  = size_w[g+1];
			end

			ffpa_cell u_cell (
				.clk         (clk),
				.capture     (accept),
				.in_count    (request.count),
				.occupied    (occ[g]),
				.ctl         (ctl),
				.left_start  (l_start),
				.left_size   (l_size),
				.right_start (r_start),
				.right_size  (r_size),
				.link_in     (link_w[g]),
				.link_out    (link_w[g+1]),
				.start_q     (start_w[g]),
				.size_q      (size_w[g])
			);
		end

		if (TOTAL_W > OUT_W) begin : g_sat
			assign total_out = (total_next > TOTAL_W'({OUT_W{1'b1}})) ?
				{OUT_W{1'b1}} : total_next[OUT_W-1:0];
		end else begin : g_ext
			assign total_out = OUT_W'(total_next);
		end
	endgenerate

	always_comb begin
		zero_cnt  = (req_q.count == '0);
		full      = (fill_q == FILL_W'(MAX_CHUNKS));
		found     = link_w[MAX_CHUNKS].found;
		ctl.count = req_q.count;
		ctl.push  = busy_q && (req_q.kind == ffpa_pkg::KIND_FREE) && !zero_cnt && !full;
		ctl.alloc = busy_q && (req_q.kind == ffpa_pkg::KIND_ALLOC) && !zero_cnt && found;

		total_next = total_q;
		fill_next  = fill_q;
		if (ctl.push) begin
			total_next = total_q + TOTAL_W'(req_q.count);
			fill_next  = fill_q + FILL_W'(1);
		end else if (ctl.alloc) begin
			total_next = (total_q >= TOTAL_W'(req_q.count)) ?
				total_q - TOTAL_W'(req_q.count) : '0;
			if (link_w[MAX_CHUNKS].remove) begin
				fill_next = fill_q - FILL_W'(1);
			end
		end

		priority if (zero_cnt) begin
			rsp.status = ffpa_pkg::ST_ZERO;
		end else if (req_q.kind == ffpa_pkg::KIND_FREE) begin
			rsp.status = full ? ffpa_pkg::ST_FULL : ffpa_pkg::ST_OK;
		end else begin
			rsp.status = found ? ffpa_pkg::ST_OK : ffpa_pkg::ST_NOFIT;
		end
		rsp.alloc_page = ctl.alloc ? link_w[MAX_CHUNKS].page : '0;
		rsp.free_total = total_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			fill_q  <= '0;
			total_q <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				fill_q  <= fill_next;
				total_q <= total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (busy_q) begin
			result_q <= rsp;
		end
	end

endmodule

[design/ffpa_checker.sv]
// Port-level checks of first_fit_page_allocator, bound to the top level.
// Depends on ffpa_pkg and first_fit_page_allocator.
module ffpa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input ffpa_pkg::ffpa_rsp_t result
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result not delivered two cycles after accept");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	a_page_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ffpa_pkg::ST_OK)) |-> (result.alloc_page == '0))
		else $error("alloc_page nonzero on failed transaction");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);
